### design/plb_pkg.sv
// Package for the positional list buffer: sizes, action and status codes,
// cell command type and the control bundle broadcast to the cell chain.
// No dependencies.
package plb_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    // action codes
    localparam logic [3:0] ACT_INS_FRONT = 4'd0;
    localparam logic [3:0] ACT_INS_BACK  = 4'd1;
    localparam logic [3:0] ACT_INS_AT    = 4'd2;
    localparam logic [3:0] ACT_DEL_FRONT = 4'd3;
    localparam logic [3:0] ACT_DEL_BACK  = 4'd4;
    localparam logic [3:0] ACT_DEL_AT    = 4'd5;
    localparam logic [3:0] ACT_CLEAR     = 4'd6;
    localparam logic [3:0] ACT_LENGTH    = 4'd7;
    localparam logic [3:0] ACT_DUMP      = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOPOS = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INS,   // cell idx loads value, cells above take the left neighbor
        CMD_DEL,   // cells at idx and above take the right neighbor
        CMD_ROT    // cells below idx take right neighbor, cell idx takes the head
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

### design/positional_list_buffer_unit.sv
// Positional list buffer: a chain of CAPACITY cells holding an ordered list,
// a request decoder and an output register. Depends on plb_pkg, plb_cell.
// A result is registered in the cycle after its transaction is accepted.
// Throughput: one non-dump request per cycle when the output is taken at once;
//   a dump emits an element per rotation of the chain while the output is free
//   and takes no request till the last; inserts and deletes shift in parallel.
// Reset: rst_n clears the element count, the state and the output valid; cell
//   contents are not reset and are only read below the count.
module positional_list_buffer_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [plb_pkg::IN_W-1:0]  s_tdata,  // action[3:0], value[35:4], position[43:36]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [plb_pkg::OUT_W-1:0] m_tdata,  // element[31:0], has_element[32],
                                                // count[39:33], status[41:40]
    output logic                      m_tlast
);
    import plb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] dump_idx_reg, dump_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_elem_reg, out_elem_next;
    logic             out_has_reg, out_has_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [1:0]       out_st_reg, out_st_next;
    logic             out_last_reg, out_last_next;

    cell_ctrl_t       ctrl;
    logic [VAL_W-1:0] cell_val [CAPACITY];

    logic [3:0]       action;
    logic [VAL_W-1:0] value;
    logic [7:0]       position;
    logic             out_free;
    logic             in_acc;
    logic             full;
    logic             empty;
    logic             pos_past;
    logic [IDX_W-1:0] count_idx;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] last_idx;

    assign action   = s_tdata[3:0];
    assign value    = s_tdata[35:4];
    assign position = s_tdata[43:36];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_past  = ({1'b0, count_reg} < position);
    assign count_idx = count_reg[IDX_W-1:0];
    assign pos_idx   = IDX_W'(position - 8'd1);
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));

    // request decode, dump sequencing and output register loading
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_elem_next  = out_elem_reg;
        out_has_next   = out_has_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;
        ctrl.cmd       = CMD_HOLD;
        ctrl.idx       = '0;
        ctrl.value     = value;

        if (in_acc)
        begin
            out_valid_next = 1'b1;
            out_elem_next  = '0;
            out_has_next   = 1'b0;
            out_st_next    = ST_OK;
            out_last_next  = 1'b1;
            case (action)
                ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
                begin
                    if (full)
                        out_st_next = ST_FULL;
                    else
                    begin
                        ctrl.cmd   = CMD_INS;
                        count_next = count_reg + CNT_W'(1);
                        if (action == ACT_INS_FRONT ||
                            (action == ACT_INS_AT && position == 8'd1))
                            ctrl.idx = '0;
                        else if (action == ACT_INS_BACK || position == 8'd0 || pos_past)
                            ctrl.idx = count_idx;
                        else
                            ctrl.idx = pos_idx;
                    end
                end
                ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
                begin
                    if (empty)
                        out_st_next = ST_EMPTY;
                    else if (action == ACT_DEL_AT && position != 8'd0 && pos_past)
                        out_st_next = ST_NOPOS;
                    else
                    begin
                        ctrl.cmd   = CMD_DEL;
                        count_next = count_reg - CNT_W'(1);
                        if (action == ACT_DEL_FRONT ||
                            (action == ACT_DEL_AT && position == 8'd1))
                            ctrl.idx = '0;
                        else if (action == ACT_DEL_BACK || position == 8'd0)
                            ctrl.idx = last_idx;
                        else
                            ctrl.idx = pos_idx;
                    end
                end
                ACT_CLEAR:
                    count_next = '0;
                ACT_DUMP:
                begin
                    if (empty)
                        out_st_next = ST_EMPTY;
                    else
                    begin
                        // first element goes out now, the rest from S_DUMP
                        ctrl.cmd      = CMD_ROT;
                        ctrl.idx      = last_idx;
                        out_elem_next = cell_val[0];
                        out_has_next  = 1'b1;
                        out_last_next = (count_reg == CNT_W'(1));
                        dump_idx_next = IDX_W'(1);
                        if (count_reg != CNT_W'(1))
                            state_next = S_DUMP;
                    end
                end
                default:
                    out_st_next = ST_OK;  // length report and unused codes
            endcase
            out_cnt_next = count_next;
        end
        else if (state_reg == S_DUMP && out_free)
        begin
            // emit the head and rotate the occupied cells by one
            ctrl.cmd       = CMD_ROT;
            ctrl.idx       = last_idx;
            out_valid_next = 1'b1;
            out_elem_next  = cell_val[0];
            out_has_next   = 1'b1;
            out_cnt_next   = count_reg;
            out_st_next    = ST_OK;
            out_last_next  = (dump_idx_reg == last_idx);
            dump_idx_next  = dump_idx_reg + IDX_W'(1);
            if (dump_idx_reg == last_idx)
                state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_elem_reg <= out_elem_next;
        out_has_reg  <= out_has_next;
        out_cnt_reg  <= out_cnt_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    // chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VAL_W-1:0] left_val;
            logic [VAL_W-1:0] right_val;

            if (gi == 0)
            begin : g_first
                assign left_val = '0;
            end
            else
            begin : g_mid_l
                assign left_val = cell_val[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_mid_r
                assign right_val = cell_val[gi+1];
            end

            plb_cell u_cell (
                .clk       (clk),
                .cell_idx  (IDX_W'(gi)),
                .ctrl      (ctrl),
                .left_val  (left_val),
                .right_val (right_val),
                .head_val  (cell_val[0]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - VAL_W - 1 - CNT_W - 2){1'b0}},
                       out_st_reg, out_cnt_reg, out_has_reg, out_elem_reg};
    assign m_tlast  = out_last_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> (count_reg != '0 && {1'b0, dump_idx_reg} < count_reg))
        else $error("dump running past the list");

    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> !s_tready)
        else $error("request taken during dump");

    a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |=> count_reg == $past(count_reg))
        else $error("count changed during dump");

endmodule

### design/plb_cell.sv
// One storage cell of the list chain: holds one element and takes its
// next value from itself, a neighbor, the head cell or the insert value.
// Depends on plb_pkg.
module plb_cell (
    input  logic                      clk,
    input  logic [plb_pkg::IDX_W-1:0] cell_idx,
    input  plb_pkg::cell_ctrl_t       ctrl,
    input  logic [plb_pkg::VAL_W-1:0] left_val,
    input  logic [plb_pkg::VAL_W-1:0] right_val,
    input  logic [plb_pkg::VAL_W-1:0] head_val,
    output logic [plb_pkg::VAL_W-1:0] val
);
    import plb_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    // next value from the broadcast command and this cell's place
    always_comb
    begin
        val_next = val_reg;
        case (ctrl.cmd)
            CMD_INS:
            begin
                if (cell_idx == ctrl.idx)
                    val_next = ctrl.value;
                else if (cell_idx > ctrl.idx)
                    val_next = left_val;
            end
            CMD_DEL:
            begin
                if (cell_idx >= ctrl.idx)
                    val_next = right_val;
            end
            CMD_ROT:
            begin
                if (cell_idx == ctrl.idx)
                    val_next = head_val;
                else if (cell_idx < ctrl.idx)
                    val_next = right_val;
            end
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
